### rtl/core/chkd_pkg.sv
`timescale 1ns / 1ps
// Package for the HTTP chunked body decoder: phase encoding, byte class and result types.
// No dependencies; imported by every module of the decoder.
package chkd_pkg;

    localparam int unsigned MAX_DIGITS = 8;
    localparam int unsigned SIZE_W     = 32;
    localparam int unsigned DCNT_W     = 4;

    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    typedef enum logic [2:0] {
        PH_SKIP_WS = 3'd0,
        PH_DIGITS  = 3'd1,
        PH_EXT     = 3'd2,
        PH_DATA    = 3'd3,
        PH_TRAILER = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    typedef struct packed {
        logic       is_ws;
        logic       is_hex;
        logic       is_semi;
        logic       is_lf;
        logic [3:0] hex_val;
    } byte_class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       body_end;
        logic       format_error;
    } result_t;

endpackage

### rtl/core/chkd_class.sv
`timescale 1ns / 1ps
// Byte classifier: whitespace, hex digit value, semicolon and line feed detection.
// Depends on chkd_pkg.
module chkd_class (
    input  logic [7:0]           in_byte,
    output chkd_pkg::byte_class_t cls
);
    import chkd_pkg::*;

    always_comb begin
        cls.is_ws   = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
        cls.is_semi = (in_byte == CHAR_SEMI);
        cls.is_lf   = (in_byte == CHAR_LF);
        cls.is_hex  = 1'b1;
        cls.hex_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            cls.hex_val = in_byte[3:0];
        end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                     (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
            // Letters a-f and A-F share their low three bits: 1..6 maps to 10..15.
            cls.hex_val = 4'd9 + {1'b0, in_byte[2:0]};
        end else begin
            cls.is_hex = 1'b0;
        end
    end

endmodule

### rtl/core/chkd_fsm.sv
`timescale 1ns / 1ps
// Decoder state machine: phase, chunk size counter and digit count, updated once per word.
// Depends on chkd_pkg; takes its byte class from chkd_class.
module chkd_fsm (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            in_byte,
    input  chkd_pkg::byte_class_t cls,
    output chkd_pkg::result_t     res
);
    import chkd_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [SIZE_W-1:0]   remaining_reg, remaining_next;
    logic [DCNT_W-1:0]   dcount_reg, dcount_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SKIP_WS;
            remaining_reg <= '0;
            dcount_reg    <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            dcount_reg    <= dcount_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        dcount_next    = dcount_reg;
        res            = '0;

        unique case (phase_reg) inside
            PH_SKIP_WS: begin
                if (cls.is_ws) begin
                    phase_next = PH_SKIP_WS;
                end else if (cls.is_hex) begin
                    remaining_next = {{(SIZE_W-4){1'b0}}, cls.hex_val};
                    dcount_next    = DCNT_W'(1);
                    phase_next     = PH_DIGITS;
                end else if (cls.is_semi) begin
                    remaining_next = '0;
                    dcount_next    = '0;
                    phase_next     = PH_EXT;
                end else begin
                    phase_next       = PH_ERROR;
                    res.format_error = 1'b1;
                end
            end
            PH_DIGITS, PH_EXT: begin
                if (phase_reg == PH_DIGITS && cls.is_hex &&
                        dcount_reg < DCNT_W'(MAX_DIGITS)) begin
                    remaining_next = {remaining_reg[SIZE_W-5:0], cls.hex_val};
                    dcount_next    = dcount_reg + DCNT_W'(1);
                end else if (cls.is_lf) begin
                    // End of the size line: payload, final trailer line, or an empty size.
                    dcount_next = '0;
                    if (dcount_reg == '0) begin
                        phase_next       = PH_ERROR;
                        res.format_error = 1'b1;
                    end else if (remaining_reg == '0) begin
                        phase_next = PH_TRAILER;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end else if (phase_reg == PH_EXT) begin
                    phase_next = PH_EXT;
                end else if (cls.is_ws || cls.is_semi) begin
                    phase_next = PH_EXT;
                end else begin
                    phase_next       = PH_ERROR;
                    res.format_error = 1'b1;
                end
            end
            PH_DATA: begin
                res.data_byte  = in_byte;
                res.data_valid = 1'b1;
                remaining_next = remaining_reg - SIZE_W'(1);
                if (remaining_reg == SIZE_W'(1)) begin
                    phase_next = PH_SKIP_WS;
                end
            end
            PH_TRAILER: begin
                if (cls.is_lf) begin
                    res.body_end   = 1'b1;
                    remaining_next = '0;
                    dcount_next    = '0;
                    phase_next     = PH_SKIP_WS;
                end
            end
            default: begin
                phase_next       = PH_ERROR;
                res.format_error = 1'b1;
            end
        endcase
    end

endmodule

### rtl/core/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// Top level of the HTTP chunked body decoder: classifier, state machine and result register.
// Depends on chkd_pkg, chkd_class and chkd_fsm.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) takes one raw byte of a chunked
//   body per word. Every accepted word gives exactly one result word on the master
//   channel: m_tdata carries the payload byte (zero when it is not payload),
//   m_tuser[0] marks a payload byte, m_tuser[1] flags a format error and m_tlast
//   marks the line feed that ends the final zero-size chunk.
//   The result word appears on m_tvalid in the cycle after its byte is accepted.
//   Throughput is one word per cycle while the receiver does not stall; the state update of each byte is a single
//   transition, done between the slave handshake and the result register.
//   When the receiver stalls, the result register holds its word and s_tready
//   falls in the same cycle, so no input is taken until the result is delivered.
//   Reset (aresetn low, synchronous) empties the result register and returns the
//   decoder to skipping whitespace before a chunk size, clearing any sticky error.
//   Once an error is flagged, every later word reports it until reset.
module http_chunked_body_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [1:0] m_tuser,   // [0] data_valid, [1] format_error
    output logic       m_tlast    // body_end
);
    import chkd_pkg::*;

    byte_class_t cls;
    result_t     res;
    logic        step;
    logic        m_tvalid_reg;
    result_t     res_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    chkd_class u_class (
        .in_byte (s_tdata),
        .cls     (cls)
    );

    chkd_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (s_tdata),
        .cls     (cls),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = res_reg.data_byte;
    assign m_tuser  = {res_reg.format_error, res_reg.data_valid};
    assign m_tlast  = res_reg.body_end;

endmodule

### rtl/core/chkd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the HTTP chunked body decoder, bound to the top level.
// Depends only on the top-level ports.
module chkd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result word must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result word changed");

    // Every accepted byte gives a result word in the next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted byte produced no result word");

    // Payload, body end and error are mutually exclusive.
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tlast && (m_tuser[0] || m_tuser[1])) && !(m_tuser[0] && m_tuser[1]))
        else $error("result word carries conflicting flags");

    // Non-payload words carry a zero data byte.
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
        else $error("non-payload word has nonzero data");

endmodule

bind http_chunked_body_decoder chkd_checker u_chkd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for http_chunked_body_decoder: directed byte table, random chunked bodies, then a
// bad size line. Uses chkd_pkg; result words are checked by the table or a byte-level model.
module tb;
    import chkd_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned LONG_HOLD   = 80;
    localparam int unsigned STAGE_WORDS = 200;

    localparam logic [2:0] F_NONE = 3'b000;   // {data_valid, body_end, format_error}
    localparam logic [2:0] F_DATA = 3'b100;
    localparam logic [2:0] F_END  = 3'b010;

    localparam logic [7:0] SPACE_CHARS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    typedef enum logic [1:0] {
        BAD_START,
        BAD_TERMINATOR,
        TOO_MANY_DIGITS,
        EMPTY_SIZE
    } fault_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       known;
        logic [7:0] want_byte;
        logic [2:0] want_flags;
    } dir_row_t;

    localparam dir_row_t DIRECTED [24] = '{
        {8'h20, 1'b1, 8'h00, F_NONE},   // whitespace straight after reset
        {8'h09, 1'b1, 8'h00, F_NONE},
        {8'h31, 1'b0, 8'h00, F_NONE},   // size 1 with an extension
        {8'h3B, 1'b0, 8'h00, F_NONE},
        {8'h61, 1'b0, 8'h00, F_NONE},
        {8'h0A, 1'b0, 8'h00, F_NONE},
        {8'hFF, 1'b1, 8'hFF, F_DATA},
        {8'h0D, 1'b0, 8'h00, F_NONE},
        {8'h0A, 1'b0, 8'h00, F_NONE},
        {8'h32, 1'b0, 8'h00, F_NONE},   // size 2 ended by a space
        {8'h20, 1'b0, 8'h00, F_NONE},
        {8'h0A, 1'b0, 8'h00, F_NONE},
        {8'h00, 1'b1, 8'h00, F_DATA},
        {8'h80, 1'b1, 8'h80, F_DATA},
        {8'h0D, 1'b0, 8'h00, F_NONE},
        {8'h0A, 1'b0, 8'h00, F_NONE},
        {8'h31, 1'b0, 8'h00, F_NONE},   // line feed directly after the digits
        {8'h0A, 1'b0, 8'h00, F_NONE},
        {8'h7F, 1'b1, 8'h7F, F_DATA},
        {8'h30, 1'b0, 8'h00, F_NONE},   // last chunk, then a trailer line
        {8'h0D, 1'b0, 8'h00, F_NONE},
        {8'h0A, 1'b0, 8'h00, F_NONE},
        {8'h78, 1'b0, 8'h00, F_NONE},
        {8'h0A, 1'b1, 8'h00, F_END}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    // Decoder model state.
    phase_t      dec_phase  = PH_SKIP_WS;
    logic [31:0] dec_left   = '0;
    logic [3:0]  dec_digits = '0;

    result_t     pending_results [$];
    result_t     want_result;
    result_t     seen_result;
    int unsigned mismatches    = 0;
    int unsigned words_sent    = 0;
    int unsigned stall_cycles  = 0;
    int unsigned hold_cycles   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    http_chunked_body_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Returns 16 for a byte that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
        if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
        return 5'd16;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + nib;
        return ($urandom_range(1) ? 8'h61 : 8'h41) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] random_space();
        return SPACE_CHARS[$urandom_range(5)];
    endfunction

    // Any byte except LF, as found inside an extension or a trailer line.
    function automatic logic [7:0] line_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CHAR_LF);
        return b;
    endfunction

    // A byte that cannot start a size line.
    function automatic logic [7:0] stray_byte();
        logic [7:0] b;
        logic [4:0] hv;
        do begin
            b  = 8'($urandom_range(255));
            hv = hex_value(b);
        end while (is_space(b) || !hv[4] || b == CHAR_SEMI);
        return b;
    endfunction

    // The size line has ended at an LF; returns the error flag.
    function automatic logic close_size_line();
        logic err;
        err = 1'b0;
        if (dec_digits == 4'd0) begin
            dec_phase = PH_ERROR;
            err       = 1'b1;
        end else if (dec_left == 32'd0) begin
            dec_phase = PH_TRAILER;
        end else begin
            dec_phase = PH_DATA;
        end
        dec_digits = 4'd0;
        return err;
    endfunction

    function automatic result_t decode_byte(input logic [7:0] c);
        result_t    r;
        logic [4:0] hv;
        r  = '0;
        hv = hex_value(c);
        case (dec_phase)
            PH_SKIP_WS: begin
                if (!is_space(c)) begin
                    if (!hv[4]) begin
                        dec_left   = {28'd0, hv[3:0]};
                        dec_digits = 4'd1;
                        dec_phase  = PH_DIGITS;
                    end else if (c == CHAR_SEMI) begin
                        dec_left   = 32'd0;
                        dec_digits = 4'd0;
                        dec_phase  = PH_EXT;
                    end else begin
                        dec_phase      = PH_ERROR;
                        r.format_error = 1'b1;
                    end
                end
            end
            PH_DIGITS: begin
                if (!hv[4] && dec_digits < MAX_DIGITS) begin
                    dec_left   = {dec_left[27:0], hv[3:0]};
                    dec_digits = dec_digits + 4'd1;
                end else if (c == CHAR_LF) begin
                    r.format_error = close_size_line();
                end else if (is_space(c) || c == CHAR_SEMI) begin
                    dec_phase = PH_EXT;
                end else begin
                    dec_phase      = PH_ERROR;
                    r.format_error = 1'b1;
                end
            end
            PH_EXT: begin
                if (c == CHAR_LF) r.format_error = close_size_line();
            end
            PH_DATA: begin
                r.data_byte  = c;
                r.data_valid = 1'b1;
                dec_left     = dec_left - 32'd1;
                if (dec_left == 32'd0) dec_phase = PH_SKIP_WS;
            end
            PH_TRAILER: begin
                if (c == CHAR_LF) begin
                    r.body_end = 1'b1;
                    dec_left   = 32'd0;
                    dec_digits = 4'd0;
                    dec_phase  = PH_SKIP_WS;
                end
            end
            default: begin
                dec_phase      = PH_ERROR;
                r.format_error = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Offers one byte and, once it is taken, queues the result word it must give.
    task automatic send_byte(input logic [7:0] b, input logic known = 1'b0,
                             input result_t want = '0);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        predicted = decode_byte(b);
        pending_results.push_back(known ? want : predicted);
        words_sent++;
    endtask

    // One well-formed chunk: leading whitespace, size line, then payload or trailer.
    task automatic send_chunk();
        int unsigned pick;
        int unsigned need;
        int unsigned ndig;
        logic [31:0] size_val;
        logic [7:0]  b;
        repeat ($urandom_range(2)) send_byte(random_space());
        pick = $urandom_range(99);
        if (pick < 15)      size_val = 32'd0;
        else if (pick < 90) size_val = $urandom_range(12, 1);
        else if (pick < 98) size_val = $urandom_range(64, 13);
        else                size_val = $urandom_range(300, 65);
        need = 1;
        while (need < MAX_DIGITS && (size_val >> (4 * need)) != 0) need++;
        ndig = $urandom_range(1) ? need : $urandom_range(MAX_DIGITS, need);
        for (int k = ndig - 1; k >= 0; k--) send_byte(hex_char(size_val[4 * k +: 4]));
        case ($urandom_range(2))
            0: send_byte(CHAR_LF);
            1: begin
                do b = random_space(); while (b == CHAR_LF);
                send_byte(b);
                repeat ($urandom_range(3)) send_byte(line_byte());
                send_byte(CHAR_LF);
            end
            default: begin
                send_byte(CHAR_SEMI);
                repeat ($urandom_range(3)) send_byte(line_byte());
                send_byte(CHAR_LF);
            end
        endcase
        if (size_val == 32'd0) begin
            repeat ($urandom_range(2)) send_byte(line_byte());
            send_byte(CHAR_LF);
        end else begin
            repeat (size_val) send_byte(8'($urandom_range(255)));
        end
    endtask

    // Receiver: random back-pressure, plus a long hold when one is requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles != 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result = {m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 20)
                    $display("%0t: none expected, got data=%h valid=%b end=%b err=%b",
                             $time, m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
            end else begin
                want_result = pending_results.pop_front();
                if (seen_result !== want_result) begin
                    mismatches++;
                    if (mismatches <= 20)
                        $display("%0t: expected %h v%b e%b x%b, got %h v%b e%b x%b",
                                 $time, want_result.data_byte, want_result.data_valid,
                                 want_result.body_end, want_result.format_error,
                                 seen_result.data_byte, seen_result.data_valid,
                                 seen_result.body_end, seen_result.format_error);
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial begin
        fault_t      fault;
        int unsigned target;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 7;
        recv_idle_pct = 61;
        for (int i = 0; i < $size(DIRECTED); i++)
            send_byte(DIRECTED[i].in_byte, DIRECTED[i].known,
                      {DIRECTED[i].want_byte, DIRECTED[i].want_flags});

        for (int stage = 0; stage < 3; stage++) begin
            if (stage == 1) begin
                send_idle_pct = 61;
                recv_idle_pct = 7;
                hold_cycles   = LONG_HOLD;
            end else if (stage == 2) begin
                // Let the decoder drain completely before the full-rate stretch.
                s_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge aclk);
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            target = words_sent + STAGE_WORDS;
            while (words_sent < target) send_chunk();
        end

        // The error state is sticky, so one malformed size line closes the run.
        fault = fault_t'($urandom_range(3));
        case (fault)
            BAD_START: begin
                send_byte(random_space());
                send_byte(stray_byte());
            end
            BAD_TERMINATOR: begin
                send_byte(hex_char(4'($urandom_range(15))));
                send_byte(stray_byte());
            end
            TOO_MANY_DIGITS: begin
                repeat (MAX_DIGITS + 1) send_byte(hex_char(4'($urandom_range(15))));
            end
            default: begin
                send_byte(CHAR_SEMI);
                repeat ($urandom_range(3)) send_byte(line_byte());
                send_byte(CHAR_LF);
            end
        endcase
        repeat ($urandom_range(8, 3)) send_byte(8'($urandom_range(255)));

        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
